// ===== src/sadstk_pkg.sv =====
package sadstk_pkg;

    localparam int DEPTH      = 256;
    localparam int ELEM_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int COUNT_W    = $clog2(DEPTH + 1);
    localparam int WORD_W     = 32;
    localparam int TOTAL_W    = 9;

    typedef logic [ADDR_W-1:0]     addr_t;
    typedef logic [COUNT_W-1:0]    count_t;
    typedef logic [COUNT_W:0]      sum_t;
    typedef logic [ELEM_WIDTH-1:0] elem_t;
    typedef logic [WORD_W-1:0]     word_t;
    typedef logic [63:0]           dword_t;
    typedef logic [TOTAL_W-1:0]    total_t;

    typedef enum logic [1:0] {
        MODE_PUSH  = 2'd0,
        MODE_POP   = 2'd1,
        MODE_PEEK  = 2'd2,
        MODE_CLEAR = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADNUM = 2'd3
    } status_t;

    localparam logic [1:0] STK_LOWER = 2'd1;
    localparam logic [1:0] STK_UPPER = 2'd2;

    // memory access issued at the accept edge
    typedef struct packed {
        logic  we;
        logic  re;
        addr_t addr;
        elem_t wdata;
    } mem_req_t;

    // result register contents, read data joins from the memory port
    typedef struct packed {
        logic    valid;
        status_t status;
        logic    read_ok;
        total_t  total;
        logic    all_empty;
    } result_t;

    // stored element: low ELEM_WIDTH bits of the sign-extended word
    function automatic elem_t word_to_elem(input logic signed [WORD_W-1:0] w);
        dword_t ext;
        ext = dword_t'(w);
        return elem_t'(ext);
    endfunction

    // read element: sign-extend from ELEM_WIDTH bits, keep the low word
    function automatic word_t elem_to_word(input elem_t e);
        logic signed [ELEM_WIDTH-1:0] s;
        dword_t                       ext;
        s   = e;
        ext = dword_t'(s);
        return word_t'(ext);
    endfunction

endpackage

// ===== src/sadstk_ram.sv =====
module sadstk_ram #(
    parameter int DEPTH_P = 256,
    parameter int WIDTH_P = 32
) (
    input  logic                       aclk,
    input  logic                       we,
    input  logic                       re,
    input  logic [$clog2(DEPTH_P)-1:0] addr,
    input  logic [WIDTH_P-1:0]         wdata,
    output logic [WIDTH_P-1:0]         rdata
);

    logic [WIDTH_P-1:0] mem [DEPTH_P];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata <= mem[addr];
        end
    end

endmodule

// ===== src/sadstk_ctrl.sv =====
module sadstk_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_mode,
    input  logic [1:0]            s_which_stack,
    input  logic signed [31:0]    s_push_value,
    input  logic                  m_ready,
    output sadstk_pkg::mem_req_t  mem_req,
    output sadstk_pkg::result_t   result
);

    sadstk_pkg::count_t  lower_reg, lower_next;
    sadstk_pkg::count_t  upper_reg, upper_next;
    sadstk_pkg::result_t rslt_reg, rslt_next;
    sadstk_pkg::sum_t    sum_now, sum_after;
    sadstk_pkg::sum_t    depth_s;
    sadstk_pkg::status_t status;
    sadstk_pkg::mem_req_t req;
    logic                read_ok;
    logic                accept;

    assign s_ready = !rslt_reg.valid || m_ready;
    assign accept  = s_valid && s_ready;
    assign depth_s = sadstk_pkg::sum_t'(sadstk_pkg::DEPTH);
    assign sum_now = {1'b0, lower_reg} + {1'b0, upper_reg};

    always_comb begin
        lower_next = lower_reg;
        upper_next = upper_reg;
        status     = sadstk_pkg::ST_OK;
        read_ok    = 1'b0;
        req.we     = 1'b0;
        req.re     = 1'b0;
        req.addr   = '0;
        req.wdata  = sadstk_pkg::word_to_elem(s_push_value);
        unique case (sadstk_pkg::mode_t'(s_mode)) inside
            sadstk_pkg::MODE_PUSH: begin
                if (sum_now >= depth_s) begin
                    status = sadstk_pkg::ST_FULL;
                end else if (s_which_stack == sadstk_pkg::STK_LOWER) begin
                    req.we     = 1'b1;
                    req.addr   = sadstk_pkg::addr_t'(lower_reg);
                    lower_next = lower_reg + sadstk_pkg::count_t'(1);
                end else if (s_which_stack == sadstk_pkg::STK_UPPER) begin
                    req.we     = 1'b1;
                    req.addr   = sadstk_pkg::addr_t'(depth_s - {1'b0, upper_reg}
                                                     - sadstk_pkg::sum_t'(1));
                    upper_next = upper_reg + sadstk_pkg::count_t'(1);
                end else begin
                    status = sadstk_pkg::ST_BADNUM;
                end
            end
            sadstk_pkg::MODE_POP, sadstk_pkg::MODE_PEEK: begin
                if (s_mode == sadstk_pkg::MODE_POP && sum_now == '0) begin
                    status = sadstk_pkg::ST_EMPTY;
                end else if (s_which_stack == sadstk_pkg::STK_LOWER) begin
                    if (lower_reg == '0) begin
                        status = sadstk_pkg::ST_EMPTY;
                    end else begin
                        req.re   = 1'b1;
                        read_ok  = 1'b1;
                        req.addr = sadstk_pkg::addr_t'(lower_reg - sadstk_pkg::count_t'(1));
                        if (s_mode == sadstk_pkg::MODE_POP) begin
                            lower_next = lower_reg - sadstk_pkg::count_t'(1);
                        end
                    end
                end else if (s_which_stack == sadstk_pkg::STK_UPPER) begin
                    if (upper_reg == '0) begin
                        status = sadstk_pkg::ST_EMPTY;
                    end else begin
                        req.re   = 1'b1;
                        read_ok  = 1'b1;
                        req.addr = sadstk_pkg::addr_t'(depth_s - {1'b0, upper_reg});
                        if (s_mode == sadstk_pkg::MODE_POP) begin
                            upper_next = upper_reg - sadstk_pkg::count_t'(1);
                        end
                    end
                end else begin
                    status = sadstk_pkg::ST_BADNUM;
                end
            end
            sadstk_pkg::MODE_CLEAR: begin
                lower_next = '0;
                upper_next = '0;
            end
            default: begin
                status = sadstk_pkg::ST_OK;
            end
        endcase
        sum_after = {1'b0, lower_next} + {1'b0, upper_next};

        rslt_next           = rslt_reg;
        rslt_next.status    = status;
        rslt_next.read_ok   = read_ok;
        rslt_next.total     = sadstk_pkg::total_t'(sum_after);
        rslt_next.all_empty = (sum_after == '0);
        rslt_next.valid     = 1'b1;
    end

    // memory sees the access only on the accept edge
    always_comb begin
        mem_req    = req;
        mem_req.we = req.we && accept;
        mem_req.re = req.re && accept;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lower_reg      <= '0;
            upper_reg      <= '0;
            rslt_reg.valid <= 1'b0;
        end else if (accept) begin
            lower_reg <= lower_next;
            upper_reg <= upper_next;
            rslt_reg  <= rslt_next;
        end else if (m_ready) begin
            rslt_reg.valid <= 1'b0;
        end
    end

    assign result = rslt_reg;

    // the two stacks never overlap
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        sum_now <= depth_s)
        else $error("stack counts exceed memory depth");

    // clear empties both stacks
    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_mode == sadstk_pkg::MODE_CLEAR |=> lower_reg == '0 && upper_reg == '0)
        else $error("clear left elements behind");

    // failed operations keep the counts
    a_fail_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && status != sadstk_pkg::ST_OK |=>
            $stable(lower_reg) && $stable(upper_reg))
        else $error("failed operation changed a count");

    // memory never both read and written at once
    a_one_access: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_req.we && mem_req.re))
        else $error("memory read and write in the same cycle");

endmodule

// ===== src/shared_array_double_stack.sv =====
// two stacks in one shared memory of sadstk_pkg::DEPTH entries: the lower stack
// grows up from entry 0, the upper stack grows down from the last entry. each
// input word is a push, pop, peek or clear, and gives exactly one result word
// with a status (ok, full, empty, bad stack number), the popped or peeked value
// (zero unless the read succeeded), the total element count and an all-empty
// flag. one word is accepted per clock cycle as long as the result side keeps
// taking results; the result appears in the cycle after acceptance, as does the data of
// the memory's registered read port, which serves exactly one push write or one
// pop/peek read per cycle. pushes and reads always land in different cycles, so
// a pop right after a push reads the freshly written entry with no stall. a full
// stack pair rejects push before the stack number is checked; clear only resets
// the counts and leaves the memory alone. no clearing pass follows reset: the
// block accepts words from the first cycle after reset is released.
module shared_array_double_stack (
    input  logic               aclk,
    input  logic               aresetn,

    // operation word
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_mode,
    input  logic [1:0]         s_which_stack,
    input  logic signed [31:0] s_push_value,

    // result word
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic signed [31:0] m_read_value,
    output logic [8:0]         m_total_count,
    output logic               m_all_empty
);

    sadstk_pkg::mem_req_t mem_req;
    sadstk_pkg::result_t  result;
    sadstk_pkg::elem_t    rdata;

    // counts, decode and the result register
    sadstk_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_which_stack (s_which_stack),
        .s_push_value  (s_push_value),
        .m_ready       (m_ready),
        .mem_req       (mem_req),
        .result        (result)
    );

    // shared element store, read data registered and held while stalled
    sadstk_ram #(
        .DEPTH_P (sadstk_pkg::DEPTH),
        .WIDTH_P (sadstk_pkg::ELEM_WIDTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_req.we),
        .re    (mem_req.re),
        .addr  (mem_req.addr),
        .wdata (mem_req.wdata),
        .rdata (rdata)
    );

    // result word: read data only on a successful pop or peek
    assign m_valid       = result.valid;
    assign m_status      = result.status;
    assign m_total_count = result.total;
    assign m_all_empty   = result.all_empty;
    assign m_read_value  = result.read_ok ? sadstk_pkg::elem_to_word(rdata) : '0;

endmodule
